[rtl/bsa_pkg.sv]
// Shared constants, types and codes of the bitmap slot allocator.
package bsa_pkg;

  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 16;
  localparam int CAP       = WORD_BITS * NUM_WORDS;

  localparam int SLOT_W   = 32;
  localparam int CNT_W    = 11;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int BASE_W = $clog2(CAP + 1);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int STEP_W = $clog2(BIT_W);
  localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int EXT_W  = (BASE_W > CNT_W) ? BASE_W : CNT_W;

  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
  localparam logic [WORD_BITS-1:0] WORD_ONE  = WORD_BITS'(1);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FIND,
    S_SCAN_WR,
    S_RUN_RD,
    S_RUN_EV,
    S_RUN_BIT,
    S_CLR_RD,
    S_CLR_WR,
    S_PT_RD,
    S_PT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

[rtl/bsa_map_mem.sv]
// Free bitmap memory with per-word valid bits so unwritten words read as all free.
module bsa_map_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsa_pkg::mem_req_t             req_i,
  output logic [bsa_pkg::WORD_BITS-1:0] rd_data_o
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem_r [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [NUM_WORDS-1:0] valid_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (req_i.wr_en) begin
      mem_r[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_r <= mem_r[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_r[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_r <= valid_r[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_r ? rd_data_r : WORD_ONES;

endmodule

[rtl/bsa_word_unit.sv]
// Shared word unit: masks a bitmap word to its usable slots and probes a stored word at or above a bit.
module bsa_word_unit (
  input  logic [bsa_pkg::WORD_BITS-1:0] raw_i,
  input  logic [bsa_pkg::BASE_W-1:0]    base_i,
  input  logic [bsa_pkg::BASE_W-1:0]    eff_i,
  input  logic [bsa_pkg::WORD_BITS-1:0] probe_word_i,
  input  logic [bsa_pkg::BIT_W-1:0]     probe_pos_i,
  output logic [bsa_pkg::WORD_BITS-1:0] live_o,
  output logic                          probe_hit_o
);
  import bsa_pkg::*;

  logic [BASE_W-1:0]    span;
  logic [WORD_BITS-1:0] usable;

  assign span = eff_i - base_i;

  always_comb begin
    if (base_i >= eff_i) begin
      usable = '0;
    end else if (span >= BASE_W'(WORD_BITS)) begin
      usable = WORD_ONES;
    end else begin
      usable = ~(WORD_ONES << span);
    end
  end

  assign live_o      = raw_i & usable;
  assign probe_hit_o = |(probe_word_i >> probe_pos_i);

endmodule

[rtl/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator: command sequencer, configuration and result register.
//
// One command is worked on at a time; in_ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next command is taken.
// The sequencer visits the free bitmap one word per memory read. Allocating one slot reads
// and evaluates each word in turn from the remembered word until one has room, then finds
// the highest free bit one bit of the word position per cycle and writes the word back.
// A run allocation walks the slots one per cycle from slot zero, pausing to read and
// evaluate each new word, then reads and rewrites each word of the claimed run.
// Allocating or freeing a named slot reads its word and writes it back when the command
// succeeds. A command rejected on its fields skips all of these. Every command hands its
// result to the output register from the done state, waiting there while the previous
// result is still held, and the sequencer returns to idle before it takes the next command.
module bitmap_slot_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bsa_pkg::CMD_W-1:0]      in_command,
  input  logic [bsa_pkg::SLOT_W-1:0]     in_slot_number,
  input  logic [bsa_pkg::CNT_W-1:0]      in_run_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bsa_pkg::STATUS_W-1:0]   out_status,
  output logic [bsa_pkg::SLOT_W-1:0]     out_result_slot,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::SLOT_W-1:0]     cfg_data
);
  import bsa_pkg::*;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]    first_slot_r;
  logic [CNT_W-1:0]     slot_count_r;
  logic [WIDX_W-1:0]    next_word_r, next_word_nxt;
  logic [BASE_W-1:0]    next_base_r, next_base_nxt;

  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]    sn_r, sn_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [WIDX_W-1:0]    word_r, word_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [WIDX_W-1:0]    k_r, k_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [BIT_W-1:0]     pos_r, pos_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [CNT_W-1:0]     run_r, run_nxt;
  logic [BASE_W-1:0]    start_r, start_nxt;
  logic [WIDX_W-1:0]    start_word_r, start_word_nxt;
  logic [BASE_W-1:0]    start_base_r, start_base_nxt;
  logic [BASE_W-1:0]    end_r, end_nxt;
  logic [BIT_W-1:0]     rem_r, rem_nxt;
  logic [WORD_BITS-1:0] raw_r, raw_nxt;
  logic [WORD_BITS-1:0] word_data_r, word_data_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] live;
  logic                 probe_hit;

  logic [EXT_W-1:0]     count_ext;
  logic [BASE_W-1:0]    eff;
  logic [SLOT_W-1:0]    idx32;
  logic                 in_accept;
  logic                 word_last;
  logic [WIDX_W-1:0]    word_inc;
  logic [BASE_W-1:0]    base_inc;
  logic [BIT_W-1:0]     cand;
  logic [BASE_W-1:0]    bit_idx;
  logic [BASE_W-1:0]    rel_start;
  logic [BASE_W-1:0]    rel_end;
  logic [BIT_W-1:0]     clr_lo;
  logic [BIT_W-1:0]     clr_hi;
  logic [WORD_BITS-1:0] clr_mask;
  logic [BIT_W-1:0]     rem_bit;

  assign count_ext = EXT_W'(slot_count_r);
  assign eff       = (count_ext < EXT_W'(CAP)) ? BASE_W'(slot_count_r) : BASE_W'(CAP);
  assign idx32     = in_slot_number - first_slot_r;
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign word_last = (word_r == WIDX_W'(NUM_WORDS - 1));
  assign word_inc  = word_last ? '0 : word_r + WIDX_W'(1);
  assign base_inc  = word_last ? '0 : base_r + BASE_W'(WORD_BITS);
  assign cand      = pos_r | (BIT_W'(1) << step_r);
  assign bit_idx   = base_r + BASE_W'(bit_r);
  assign rel_start = start_r - base_r;
  assign rel_end   = end_r - base_r;
  assign clr_lo    = (start_r > base_r) ? rel_start[BIT_W-1:0] : '0;
  assign clr_hi    = (rel_end >= BASE_W'(WORD_BITS)) ? BIT_W'(WORD_BITS - 1)
                                                    : rel_end[BIT_W-1:0];
  assign clr_mask  = (WORD_ONES << clr_lo) & (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - clr_hi));
  assign rem_bit   = rem_r;

  bsa_map_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  bsa_word_unit u_unit (
    .raw_i        (rd_data),
    .base_i       (base_r),
    .eff_i        (eff),
    .probe_word_i (word_data_r),
    .probe_pos_i  (cand),
    .live_o       (live),
    .probe_hit_o  (probe_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_slot_r <= '0;
      slot_count_r <= CNT_W'(1024);
      next_word_r  <= '0;
      next_base_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_word_r <= next_word_nxt;
      next_base_r <= next_base_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_SLOT: first_slot_r <= cfg_data;
          CFG_SLOT_COUNT: slot_count_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    sn_r         <= sn_nxt;
    len_r        <= len_nxt;
    word_r       <= word_nxt;
    base_r       <= base_nxt;
    k_r          <= k_nxt;
    bit_r        <= bit_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    start_word_r <= start_word_nxt;
    start_base_r <= start_base_nxt;
    end_r        <= end_nxt;
    rem_r        <= rem_nxt;
    raw_r        <= raw_nxt;
    word_data_r  <= word_data_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    next_word_nxt  = next_word_r;
    next_base_nxt  = next_base_r;
    cmd_nxt        = cmd_r;
    sn_nxt         = sn_r;
    len_nxt        = len_r;
    word_nxt       = word_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    bit_nxt        = bit_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    start_word_nxt = start_word_r;
    start_base_nxt = start_base_r;
    end_nxt        = end_r;
    rem_nxt        = rem_r;
    raw_nxt        = raw_r;
    word_data_nxt  = word_data_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt  = in_command;
          sn_nxt   = in_slot_number;
          len_nxt  = in_run_length;
          res_slot_nxt = '0;
          case (in_command)
            CMD_ALLOC: begin
              word_nxt  = next_word_r;
              base_nxt  = next_base_r;
              k_nxt     = '0;
              state_nxt = S_SCAN_RD;
            end
            CMD_RUN: begin
              if (in_run_length == '0) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else if (eff == '0) begin
                res_status_nxt = ST_NOSPACE;
                state_nxt      = S_DONE;
              end else begin
                word_nxt  = '0;
                base_nxt  = '0;
                run_nxt   = '0;
                state_nxt = S_RUN_RD;
              end
            end
            default: begin
              if (idx32 >= SLOT_W'(eff)) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                rem_nxt   = idx32[BIT_W-1:0];
                word_nxt  = idx32[BIT_W +: WIDX_W];
                state_nxt = S_PT_RD;
              end
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = word_r;
        state_nxt       = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        if (live != '0) begin
          raw_nxt       = rd_data;
          word_data_nxt = live;
          pos_nxt       = '0;
          step_nxt      = STEP_W'(BIT_W - 1);
          state_nxt     = S_FIND;
        end else if (k_r == WIDX_W'(NUM_WORDS - 1)) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_DONE;
        end else begin
          k_nxt     = k_r + WIDX_W'(1);
          word_nxt  = word_inc;
          base_nxt  = base_inc;
          state_nxt = S_SCAN_RD;
        end
      end

      S_FIND: begin
        if (probe_hit) begin
          pos_nxt = cand;
        end
        if (step_r == '0) begin
          state_nxt = S_SCAN_WR;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end

      S_SCAN_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = word_r;
        mem_req.wr_data = raw_r & ~(WORD_ONE << pos_r);
        next_word_nxt   = word_r;
        next_base_nxt   = base_r;
        res_status_nxt  = ST_OK;
        res_slot_nxt    = first_slot_r + SLOT_W'(base_r) + SLOT_W'(pos_r);
        state_nxt       = S_DONE;
      end

      S_RUN_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = word_r;
        state_nxt       = S_RUN_EV;
      end

      S_RUN_EV: begin
        word_data_nxt = live;
        bit_nxt       = '0;
        state_nxt     = S_RUN_BIT;
      end

      S_RUN_BIT: begin
        if (word_data_r[bit_r] && (run_r + CNT_W'(1) == len_r)) begin
          end_nxt = bit_idx;
          if (run_r == '0) begin
            start_nxt = bit_idx;
            word_nxt  = word_r;
            base_nxt  = base_r;
          end else begin
            word_nxt  = start_word_r;
            base_nxt  = start_base_r;
          end
          state_nxt = S_CLR_RD;
        end else begin
          if (word_data_r[bit_r]) begin
            if (run_r == '0) begin
              start_nxt      = bit_idx;
              start_word_nxt = word_r;
              start_base_nxt = base_r;
            end
            run_nxt = run_r + CNT_W'(1);
          end else begin
            run_nxt = '0;
          end
          if (bit_idx == eff - BASE_W'(1)) begin
            res_status_nxt = ST_NOSPACE;
            state_nxt      = S_DONE;
          end else if (bit_r == BIT_W'(WORD_BITS - 1)) begin
            word_nxt  = word_inc;
            base_nxt  = base_inc;
            state_nxt = S_RUN_RD;
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
          end
        end
      end

      S_CLR_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = word_r;
        state_nxt       = S_CLR_WR;
      end

      S_CLR_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = word_r;
        mem_req.wr_data = rd_data & ~clr_mask;
        if (rel_end < BASE_W'(WORD_BITS)) begin
          res_status_nxt = ST_OK;
          res_slot_nxt   = first_slot_r + SLOT_W'(start_r);
          state_nxt      = S_DONE;
        end else begin
          word_nxt  = word_inc;
          base_nxt  = base_inc;
          state_nxt = S_CLR_RD;
        end
      end

      S_PT_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = word_r;
        state_nxt       = S_PT_WR;
      end

      S_PT_WR: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_AT) begin
          if (!rd_data[rem_bit]) begin
            res_status_nxt = ST_TAKEN;
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = word_r;
            mem_req.wr_data = rd_data & ~(WORD_ONE << rem_bit);
            res_status_nxt  = ST_OK;
            res_slot_nxt    = sn_r;
          end
        end else begin
          if (rd_data[rem_bit]) begin
            res_status_nxt = ST_FREE;
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = word_r;
            mem_req.wr_data = rd_data | (WORD_ONE << rem_bit);
            res_status_nxt  = ST_OK;
            res_slot_nxt    = sn_r;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = (res_status_r == ST_OK) ? res_slot_r : '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ready)
    else $error("allocator took a command without leaving idle");

  a_error_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_result_slot == '0))
    else $error("failed command returned a nonzero slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FREE))
    else $error("result carries an undefined status code");

  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> ((state_r != S_IDLE) && (state_r != S_DONE)))
    else $error("bitmap written outside a command");

  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("finished result not moved to the output register");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bitmap slot allocator, with its own allocation predictor.
module tb_top;
  import bsa_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } grant_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_ALLOC;
  logic [SLOT_W-1:0]    in_slot_number = '0;
  logic [CNT_W-1:0]     in_run_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W-1:0]    out_result_slot;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_SLOT;
  logic [SLOT_W-1:0]    cfg_data = '0;

  logic [WORD_BITS-1:0] shadow_map [NUM_WORDS];
  logic [WIDX_W-1:0]    shadow_next;
  logic [SLOT_W-1:0]    shadow_first;
  logic [CNT_W-1:0]     shadow_count;
  grant_t               grant_q [$];
  logic [SLOT_W-1:0]    held_slots [$];
  int unsigned          mismatches = 0;
  int unsigned          burst_left = 0;
  int unsigned          stall_mode = 0;
  int unsigned          stall_left = 0;

  bitmap_slot_allocator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_slot_number  (in_slot_number),
    .in_run_length   (in_run_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned usable_slots();
    return (shadow_count < CAP) ? int'(shadow_count) : CAP;
  endfunction

  function automatic logic [WORD_BITS-1:0] live_bits(int unsigned w);
    int unsigned lim;
    int unsigned base;
    lim = usable_slots();
    base = w * WORD_BITS;
    if (base >= lim) return '0;
    if (lim - base >= WORD_BITS) return shadow_map[w];
    return shadow_map[w] & ((WORD_ONE << (lim - base)) - WORD_ONE);
  endfunction

  function automatic bit slot_free(int unsigned idx);
    if (idx >= usable_slots()) return 1'b0;
    return shadow_map[idx / WORD_BITS][idx % WORD_BITS];
  endfunction

  function automatic void predict_grant(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sn,
                                        logic [CNT_W-1:0] len);
    grant_t               g;
    int unsigned          w, k, c, b, i, start, run, lim;
    logic [WORD_BITS-1:0] v;
    logic [SLOT_W-1:0]    idx;
    bit                   found;
    g.status = ST_OK;
    g.slot = '0;
    lim = usable_slots();
    case (cmd)
      CMD_ALLOC: begin
        w = shadow_next;
        found = (live_bits(w) != '0);
        for (k = 1; !found && k < NUM_WORDS; k++) begin
          c = (w + k) % NUM_WORDS;
          if (live_bits(c) != '0) begin
            w = c;
            found = 1'b1;
          end
        end
        if (!found) begin
          g.status = ST_NOSPACE;
        end else begin
          v = live_bits(w);
          b = WORD_BITS - 1;
          while (!v[b]) b--;
          shadow_next = WIDX_W'(w);
          shadow_map[w][b] = 1'b0;
          g.slot = shadow_first + w * WORD_BITS + b;
        end
      end
      CMD_RUN: begin
        if (len == '0) begin
          g.status = ST_RANGE;
        end else begin
          start = 0;
          run = 0;
          for (i = 0; i < lim && run < len; i++) begin
            if (slot_free(i)) begin
              if (run == 0) start = i;
              run++;
            end else begin
              run = 0;
            end
          end
          if (run < len) begin
            g.status = ST_NOSPACE;
          end else begin
            for (i = start; i < start + len; i++) shadow_map[i / WORD_BITS][i % WORD_BITS] = 1'b0;
            g.slot = shadow_first + start;
          end
        end
      end
      default: begin
        idx = sn - shadow_first;
        if (idx >= lim) begin
          g.status = ST_RANGE;
        end else if (cmd == CMD_AT) begin
          if (!slot_free(idx)) begin
            g.status = ST_TAKEN;
          end else begin
            shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
            g.slot = sn;
          end
        end else begin
          if (slot_free(idx)) begin
            g.status = ST_FREE;
          end else begin
            shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
            g.slot = sn;
          end
        end
      end
    endcase
    if (g.status == ST_OK && cmd != CMD_FREE) begin
      held_slots.push_back(g.slot);
      if (held_slots.size() > 64) void'(held_slots.pop_front());
    end
    grant_q.push_back(g);
  endfunction

  task automatic flag_mismatch(string field, logic [SLOT_W-1:0] want, logic [SLOT_W-1:0] got);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        flag_mismatch("unexpected result_slot", '0, out_result_slot);
      end else begin
        want = grant_q.pop_front();
        if (out_status !== want.status) begin
          flag_mismatch("status", SLOT_W'(want.status), SLOT_W'(out_status));
        end
        if (out_result_slot !== want.slot) flag_mismatch("result_slot", want.slot, out_result_slot);
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(2);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(1);
      default: out_ready <= ($urandom_range(15) == 0);
    endcase
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sn, logic [CNT_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_slot_number <= sn;
    in_run_length <= len;
    do @(posedge clk); while (!in_ready);
    predict_grant(cmd, sn, len);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLOT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_SLOT) shadow_first = data;
    else if (idx == CFG_SLOT_COUNT) shadow_count = data[CNT_W-1:0];
  endtask

  task automatic configure(logic [SLOT_W-1:0] first, logic [CNT_W-1:0] count, bit spares);
    logic [SLOT_W-1:0] count_word;
    settle();
    count_word = $urandom;
    count_word[CNT_W-1:0] = count;
    write_reg(CFG_FIRST_SLOT, first);
    if (spares) write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SLOT_COUNT, count_word);
    if (spares) write_reg(CFG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
    held_slots.delete();
  endtask

  task automatic random_items(int unsigned n);
    int unsigned       pick;
    int unsigned       lim;
    int unsigned       j;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] sn;
    logic [CNT_W-1:0]  len;
    repeat (n) begin
      pick = $urandom_range(99);
      lim = usable_slots();
      cmd = (pick < 30) ? CMD_ALLOC : (pick < 45) ? CMD_RUN : (pick < 70) ? CMD_AT : CMD_FREE;
      pick = $urandom_range(99);
      len = (pick < 85) ? CNT_W'($urandom_range(1, 8)) :
            (pick < 97) ? CNT_W'($urandom_range(9, 64)) : CNT_W'($urandom);
      if (cmd == CMD_FREE && held_slots.size() != 0 && $urandom_range(99) < 60) begin
        j = $urandom_range(held_slots.size() - 1);
        sn = held_slots[j];
        held_slots.delete(j);
      end else if ($urandom_range(9) == 0) begin
        sn = $urandom;
      end else begin
        sn = shadow_first + $urandom_range(lim + 3);
      end
      send_item(cmd, sn, len);
    end
  endtask

  task automatic test_reset_map();
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_RUN, '0, 11'd1);
    send_item(CMD_RUN, '0, 11'd0);
    send_item(CMD_RUN, '0, 11'h7FF);
    send_item(CMD_RUN, '0, 11'd1024);
    send_item(CMD_AT, 32'd1023, '0);
    send_item(CMD_AT, 32'd1023, '0);
    send_item(CMD_AT, 32'd1024, '0);
    send_item(CMD_FREE, 32'hFFFF_FFFF, 11'h7FF);
    send_item(CMD_FREE, 32'd500, '0);
    send_item(CMD_FREE, 32'd1023, '0);
    send_item(CMD_FREE, 32'd63, '0);
    send_item(CMD_FREE, 32'd0, '0);
    send_item(CMD_RUN, '0, 11'd1024);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, 32'd700, '0);
    send_item(CMD_FREE, 32'd5, '0);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, 32'd3, '0);
    send_item(CMD_ALLOC, '0, '0);
  endtask

  task automatic test_wrapped_base();
    configure(32'hFFFF_FFF0, 11'd100, 1'b0);
    random_items(300);
  endtask

  task automatic test_zero_count();
    configure(32'hFFFF_FFFF, 11'd0, 1'b0);
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_RUN, '0, 11'd1);
    send_item(CMD_AT, 32'hFFFF_FFFF, '0);
    send_item(CMD_FREE, 32'hFFFF_FFFF, '0);
    random_items(16);
  endtask

  task automatic test_oversize_count();
    configure(32'h0000_0000, 11'h7FF, 1'b0);
    random_items(450);
  endtask

  task automatic test_single_slot();
    configure($urandom, 11'd1, 1'b0);
    random_items(60);
  endtask

  task automatic test_partial_word();
    configure($urandom, 11'd70, 1'b0);
    random_items(300);
  endtask

  task automatic test_ignored_index();
    configure($urandom, 11'd640, 1'b1);
    random_items(230);
  endtask

  task automatic test_full_range();
    configure(32'h0001_2345, 11'd1024, 1'b0);
    random_items(400);
  endtask

  initial begin
    for (int w = 0; w < NUM_WORDS; w++) shadow_map[w] = WORD_ONES;
    shadow_next = '0;
    shadow_first = '0;
    shadow_count = 11'd1024;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_map();
    test_wrapped_base();
    test_zero_count();
    test_oversize_count();
    test_single_slot();
    test_partial_word();
    test_ignored_index();
    test_full_range();
    settle();
    repeat (32) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("[bitmap_slot_allocator] OK");
    end else begin
      $display("[bitmap_slot_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[bitmap_slot_allocator] ERROR");
    $finish;
  end

endmodule
